// ----- sv/gimbal_aim_angles_defines.svh -----
// Assertion macros used by the checker file.
`ifndef GIMBAL_AIM_ANGLES_DEFINES_SVH
`define GIMBAL_AIM_ANGLES_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GAA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gaa check failed");

// Next-cycle implication, held off during reset.
`define GAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gaa check failed");

// Next-cycle implication that also covers the reset cycles.
`define GAA_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gaa reset check failed");

`endif

// ----- sv/gaa_pkg.sv -----
package gaa_pkg;

  // Default and hard limit of the rotation chain length.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TABLE_LEN    = 24;

  // Datapath widths.
  localparam int OPW   = 56;  // rotation operands
  localparam int ACCW  = 26;  // angle accumulator, 2^21 units per radian
  localparam int SQW   = 32;  // x^2 + z^2
  localparam int ROOTW = 32;  // floor(sqrt(sq * 2^32))
  localparam int REMW  = 34;

  localparam logic signed [ACCW-1:0] ACC_PI = 26'sd6588397;

  // Register indexes.
  localparam logic [2:0] REG_OFFSET_X  = 3'd0;
  localparam logic [2:0] REG_OFFSET_Z  = 3'd1;
  localparam logic [2:0] REG_PITCH_BIAS = 3'd2;
  localparam logic [2:0] REG_YAW_BIAS  = 3'd3;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } out_beat_t;

  // Values that ride along the square-root chain.
  typedef struct packed {
    logic signed [15:0] py;
    logic signed [16:0] sx;
    logic signed [16:0] sz;
  } side_t;

  typedef struct packed {
    logic             valid;
    logic [SQW-1:0]   n;
    logic [REMW-1:0]  rem;
    logic [ROOTW-1:0] root;
    side_t            side;
  } sqrt_beat_t;

  typedef struct packed {
    logic signed [OPW-1:0]  x;
    logic signed [OPW-1:0]  y;
    logic signed [ACCW-1:0] acc;
    logic                   zero;
  } lane_t;

  typedef struct packed {
    logic  valid;
    lane_t pitch;
    lane_t yaw;
  } cordic_beat_t;

  // atan(2^-i) in 2^21 units per radian, rounded to nearest.
  function automatic logic [20:0] atan_entry(input int i);
    logic [20:0] v;
    case (i)
      0: v = 21'd1647099;
      1: v = 21'd972340;
      2: v = 21'd513757;
      3: v = 21'd260791;
      4: v = 21'd130902;
      5: v = 21'd65515;
      6: v = 21'd32765;
      7: v = 21'd16384;
      8: v = 21'd8192;
      9: v = 21'd4096;
      10: v = 21'd2048;
      11: v = 21'd1024;
      12: v = 21'd512;
      13: v = 21'd256;
      14: v = 21'd128;
      15: v = 21'd64;
      16: v = 21'd32;
      17: v = 21'd16;
      18: v = 21'd8;
      19: v = 21'd4;
      20: v = 21'd2;
      21: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/gaa_sqrt_cell.sv -----
module gaa_sqrt_cell
  import gaa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  sqrt_beat_t beat_in,
  output sqrt_beat_t beat_out
);

  logic [REMW+1:0]  cur;
  logic [REMW+1:0]  trial;
  sqrt_beat_t       beat_r;
  sqrt_beat_t       beat_nxt;

  // One result bit: bring down two radicand bits and try to subtract.
  always_comb begin
    cur      = {beat_in.rem, beat_in.n[SQW-1 -: 2]};
    trial    = {2'b00, beat_in.root, 2'b01};
    beat_nxt = beat_in;
    beat_nxt.n = {beat_in.n[SQW-3:0], 2'b00};
    if (cur >= trial) begin
      beat_nxt.rem  = REMW'(cur - trial);
      beat_nxt.root = {beat_in.root[ROOTW-2:0], 1'b1};
    end else begin
      beat_nxt.rem  = cur[REMW-1:0];
      beat_nxt.root = {beat_in.root[ROOTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule

// ----- sv/gaa_cordic_cell.sv -----
module gaa_cordic_cell
  import gaa_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  cordic_beat_t beat_in,
  output cordic_beat_t beat_out
);

  localparam logic signed [ACCW-1:0] STEP = ACCW'(signed'({1'b0, atan_entry(STAGE)}));

  cordic_beat_t beat_r;
  cordic_beat_t beat_nxt;

  // Vectoring step: rotate toward y = 0 and track the angle taken.
  function automatic lane_t rotate(input lane_t l);
    lane_t o;
    o = l;
    if (l.y >= 0) begin
      o.x   = l.x + (l.y >>> STAGE);
      o.y   = l.y - (l.x >>> STAGE);
      o.acc = l.acc + STEP;
    end else begin
      o.x   = l.x - (l.y >>> STAGE);
      o.y   = l.y + (l.x >>> STAGE);
      o.acc = l.acc - STEP;
    end
    return o;
  endfunction

  always_comb begin
    beat_nxt       = beat_in;
    beat_nxt.pitch = rotate(beat_in.pitch);
    beat_nxt.yaw   = rotate(beat_in.yaw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule

// ----- sv/gimbal_aim_angles.sv -----
// Aim angle converter: a target position in, pitch and yaw angles out.
// Input channel: in_valid / in_ready carry one beat of in_data (pos_x, pos_y,
// pos_z, signed millimetres). Output channel: out_valid / out_ready carry one
// beat of out_data (pitch_angle, yaw_angle, 8192 units per radian, saturated).
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 x offset, 1 z offset, 2 pitch bias, 3 yaw bias); other indexes are ignored.
// From acceptance to out_valid a beat passes the squares register, the sum
// register, 32 square-root cells, the operand setup register, the rotation
// cells, and the output register.
// Throughput is one beat per cycle unless stalled; the whole chain moves together.
// When the receiver stalls a waiting result, every cell holds and in_ready
// drops in the same cycle, so nothing is lost or overwritten.
// Synchronous reset empties the pipeline and clears the configuration
// registers to zero.
module gimbal_aim_angles
  import gaa_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int NS = (CORDIC_STAGES > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STAGES;

  logic signed [15:0] offset_x_r, offset_z_r, pitch_bias_r, yaw_bias_r;
  logic adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r   <= '0;
      offset_z_r   <= '0;
      pitch_bias_r <= '0;
      yaw_bias_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OFFSET_X:   offset_x_r   <= cfg_wdata;
        REG_OFFSET_Z:   offset_z_r   <= cfg_wdata;
        REG_PITCH_BIAS: pitch_bias_r <= cfg_wdata;
        REG_YAW_BIAS:   yaw_bias_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The chain advances unless a finished result is held by the receiver.
  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  // Squares and offset sums.
  logic        a_valid_r;
  logic [30:0] x2_r, z2_r;
  side_t       a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      x2_r      <= 31'(unsigned'(32'(in_data.pos_x) * 32'(in_data.pos_x)));
      z2_r      <= 31'(unsigned'(32'(in_data.pos_z) * 32'(in_data.pos_z)));
      a_side_r.py <= in_data.pos_y;
      a_side_r.sx <= 17'(in_data.pos_x) + 17'(offset_x_r);
      a_side_r.sz <= 17'(in_data.pos_z) + 17'(offset_z_r);
    end
  end

  // Horizontal distance squared enters the square-root chain.
  sqrt_beat_t sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.valid <= 1'b0;
    end else if (adv) begin
      sq_r.valid <= a_valid_r;
      sq_r.n     <= SQW'(x2_r) + SQW'(z2_r);
      sq_r.rem   <= '0;
      sq_r.root  <= '0;
      sq_r.side  <= a_side_r;
    end
  end

  sqrt_beat_t sq_chain [ROOTW+1];
  assign sq_chain[0] = sq_r;

  for (genvar g = 0; g < ROOTW; g++) begin : g_sqrt
    gaa_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .beat_in  (sq_chain[g]),
      .beat_out (sq_chain[g+1])
    );
  end

  // Operand setup: scale, fold the left half plane, flag the origin.
  function automatic lane_t setup(input logic signed [OPW-1:0] xa,
                                  input logic signed [OPW-1:0] ya,
                                  input logic z);
    lane_t l;
    l.zero = z;
    if (xa < 0) begin
      l.x   = -xa;
      l.y   = -ya;
      l.acc = (ya >= 0) ? ACC_PI : -ACC_PI;
    end else begin
      l.x   = xa;
      l.y   = ya;
      l.acc = '0;
    end
    return l;
  endfunction

  sqrt_beat_t   sq_last;
  cordic_beat_t prep_r;
  assign sq_last = sq_chain[ROOTW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (adv) begin
      prep_r.valid <= sq_last.valid;
      prep_r.pitch <= setup(signed'({{(OPW-ROOTW){1'b0}}, sq_last.root}) <<< 20,
                            OPW'(sq_last.side.py) <<< 36,
                            (sq_last.side.py == 0) && (sq_last.root == 0));
      prep_r.yaw   <= setup(OPW'(sq_last.side.sz) <<< 36,
                            OPW'(sq_last.side.sx) <<< 36,
                            (sq_last.side.sx == 0) && (sq_last.side.sz == 0));
    end
  end

  cordic_beat_t cd_chain [NS+1];
  assign cd_chain[0] = prep_r;

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    gaa_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .beat_in  (cd_chain[g]),
      .beat_out (cd_chain[g+1])
    );
  end

  // Round to 8192 units per radian (zero at the origin), negate, add bias and saturate.
  function automatic logic signed [15:0] finish(input lane_t l,
                                                input logic signed [15:0] bias);
    logic signed [ACCW-1:0] rnd;
    logic signed [17:0]     a;
    logic signed [19:0]     v;
    rnd = l.acc + ACCW'(128);
    a   = l.zero ? 18'sd0 : 18'(rnd >>> 8);
    v   = -20'(a) + 20'(bias);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  cordic_beat_t cd_last;
  logic         out_valid_r;
  out_beat_t    out_data_r;
  assign cd_last = cd_chain[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r            <= cd_last.valid;
      out_data_r.pitch_angle <= finish(cd_last.pitch, pitch_bias_r);
      out_data_r.yaw_angle   <= finish(cd_last.yaw, yaw_bias_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/gaa_checker.sv -----
`include "gimbal_aim_angles_defines.svh"

module gaa_checker
  import gaa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // A stalled result stays put.
  `GAA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // No new beat is taken while a result is held back.
  `GAA_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)

  // Reset leaves no result pending.
  `GAA_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind gimbal_aim_angles gaa_checker u_gaa_checker (.*);
